// ===== design/array_sort_and_statistics_unit_assert.svh =====
// assertion macros for the array sort and statistics unit
`ifndef ARRAY_SORT_AND_STATISTICS_UNIT_ASSERT_SVH
`define ARRAY_SORT_AND_STATISTICS_UNIT_ASSERT_SVH

// condition must never hold while out of reset
`define ASU_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

// antecedent in one cycle implies consequent in the next
`define ASU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/asu_pkg.sv =====
// shared constants and link types of the array sort and statistics unit
package asu_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_W     = 32;
  localparam int SUM_W      = 40;
  localparam int MATCH_W    = 7;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GROUP_W    = $clog2(GROUP_SIZE + 1);

  // what one cell shows its neighbors
  typedef struct packed {
    logic                     valid;
    logic                     lt;
    logic signed [DATA_W-1:0] value;
  } cell_link_t;

  // per-cycle commands broadcast along the row
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== design/array_sort_and_statistics_unit.sv =====
// after the closing item, ST_COUNT_A and ST_COUNT_B pass before the first sorted result
// throughput: in ST_LOAD one item per cycle is taken, sorted by a row of insertion cells
// unloading gives one result per cycle from the head cell while out_ready is high;
// the input stays blocked from a set's closing item until its last result is taken
// reset: fill count, cell valid bits, flags and match_reg clear at once; no clearing pass
`include "array_sort_and_statistics_unit_assert.svh"

module array_sort_and_statistics_unit (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic signed [asu_pkg::DATA_W-1:0]  match_value,
  // input items
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [asu_pkg::DATA_W-1:0]  element,
  input  logic                               final_element,
  // result items
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [asu_pkg::DATA_W-1:0]  sorted_value,
  output logic                               end_of_run,
  output logic signed [asu_pkg::DATA_W-1:0]  largest,
  output logic signed [asu_pkg::DATA_W-1:0]  smallest,
  output logic signed [asu_pkg::SUM_W-1:0]   total,
  output logic [asu_pkg::MATCH_W-1:0]        match_count,
  output logic                               overflowed
);

  // load, then ST_COUNT_A and ST_COUNT_B for the match count tree, then unload
  typedef enum logic [3:0] {
    ST_LOAD    = 4'b0001,
    ST_COUNT_A = 4'b0010,
    ST_COUNT_B = 4'b0100,
    ST_UNLOAD  = 4'b1000
  } state_t;

  state_t                              state;
  state_t                              state_next;
  logic [asu_pkg::CNT_W-1:0]           fill_count;
  logic signed [asu_pkg::DATA_W-1:0]   match_reg;
  logic                                in_fire;
  logic                                out_fire;
  logic                                stored;
  logic                                fresh;
  logic [asu_pkg::CNT_W-1:0]           match_total;
  asu_pkg::cell_ctrl_t                 ctrl;
  asu_pkg::cell_link_t                 links   [asu_pkg::CAPACITY];
  asu_pkg::cell_link_t                 lowers  [asu_pkg::CAPACITY];
  asu_pkg::cell_link_t                 uppers  [asu_pkg::CAPACITY];
  logic [asu_pkg::CAPACITY-1:0]        eq_bits;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_LOAD);
  assign out_valid = (state == ST_UNLOAD);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // values past capacity are dropped but still close the set
  assign stored = (fill_count < asu_pkg::CNT_W'(asu_pkg::CAPACITY));
  assign fresh  = (fill_count == '0);

  assign ctrl.insert = in_fire && stored;
  assign ctrl.shift  = out_fire;

  // match register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      match_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      match_reg <= match_value;
    end
  end

  // row of cells, head holds the smallest value
  for (genvar i = 0; i < asu_pkg::CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      // the head sees a valid neighbor that is never greater
      assign lowers[i] = '{valid: 1'b1, lt: 1'b0, value: '0};
    end else begin : g_mid
      assign lowers[i] = links[i-1];
    end
    if (i == asu_pkg::CAPACITY - 1) begin : g_tail
      assign uppers[i] = '{valid: 1'b0, lt: 1'b0, value: '0};
    end else begin : g_body
      assign uppers[i] = links[i+1];
    end

    asu_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_value   (element),
      .match_value (match_reg),
      .lower       (lowers[i]),
      .upper       (uppers[i]),
      .link        (links[i]),
      .eq          (eq_bits[i])
    );
  end

  // counts matches over the settled row while the fsm waits
  asu_match_counter u_match_counter (
    .clk   (clk),
    .eq    (eq_bits),
    .count (match_total)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_fire && final_element) begin
          state_next = ST_COUNT_A;
        end
      end
      ST_COUNT_A: begin
        state_next = ST_COUNT_B;
      end
      ST_COUNT_B: begin
        state_next = ST_UNLOAD;
      end
      ST_UNLOAD: begin
        if (out_fire && end_of_run) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // fill count doubles as the number of results still to deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (ctrl.insert) begin
      fill_count <= fill_count + asu_pkg::CNT_W'(1);
    end else if (out_fire) begin
      fill_count <= fill_count - asu_pkg::CNT_W'(1);
    end
  end

  // running statistics, restarted by the first item of a set
  always_ff @(posedge clk) begin
    if (rst) begin
      overflowed <= 1'b0;
    end else if (in_fire) begin
      overflowed <= (fresh ? 1'b0 : overflowed) | !stored;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (fresh) begin
        largest  <= element;
        smallest <= element;
        total    <= asu_pkg::SUM_W'(element);
      end else begin
        if (element > largest) begin
          largest <= element;
        end
        if (element < smallest) begin
          smallest <= element;
        end
        total <= total + asu_pkg::SUM_W'(element);
      end
    end
  end

  // group counts register at the end of ST_COUNT_A, their sum is taken here in ST_COUNT_B
  always_ff @(posedge clk) begin
    if (state == ST_COUNT_B) begin
      match_count <= asu_pkg::MATCH_W'(match_total);
    end
  end

  assign sorted_value = links[0].value;
  assign end_of_run   = (fill_count == asu_pkg::CNT_W'(1));

  // a result is only offered while the head cell holds a value
  `ASU_ASSERT_NEVER(a_out_needs_head, out_valid && !links[0].valid)
  // fill count never passes capacity
  `ASU_ASSERT_NEVER(a_fill_bound, fill_count > asu_pkg::CNT_W'(asu_pkg::CAPACITY))
  // the last result empties the row and reopens the input
  `ASU_ASSERT_NEXT(a_last_reopens, out_fire && end_of_run,
                   in_ready && !links[0].valid && fill_count == '0)

endmodule

// ===== design/asu_cell.sv =====
// one cell of the insertion sorting row
module asu_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  asu_pkg::cell_ctrl_t              ctrl,
  input  logic signed [asu_pkg::DATA_W-1:0] new_value,
  input  logic signed [asu_pkg::DATA_W-1:0] match_value,
  input  asu_pkg::cell_link_t              lower,
  input  asu_pkg::cell_link_t              upper,
  output asu_pkg::cell_link_t              link,
  output logic                             eq
);

  logic                             valid;
  logic signed [asu_pkg::DATA_W-1:0] value;
  logic                             lt_own;

  assign lt_own = valid && (new_value < value);
  assign eq     = valid && (value == match_value);

  assign link.valid = valid;
  assign link.lt    = lt_own;
  assign link.value = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= upper.valid;
    end else if (ctrl.insert) begin
      valid <= valid | lower.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= upper.value;
    end else if (ctrl.insert) begin
      // lower neighbor moves up, or the new value lands here
      if (lower.lt) begin
        value <= lower.value;
      end else if (lt_own || (!valid && lower.valid)) begin
        value <= new_value;
      end
    end
  end

endmodule

// ===== design/asu_match_counter.sv =====
// registered per-group counts of the cell match flags, summed into one count
module asu_match_counter (
  input  logic                         clk,
  input  logic [asu_pkg::CAPACITY-1:0] eq,
  output logic [asu_pkg::CNT_W-1:0]    count
);

  logic [asu_pkg::NUM_GROUPS*asu_pkg::GROUP_SIZE-1:0] eq_pad;
  logic [asu_pkg::GROUP_W-1:0] group_count [asu_pkg::NUM_GROUPS];

  assign eq_pad = (asu_pkg::NUM_GROUPS*asu_pkg::GROUP_SIZE)'(eq);

  always_ff @(posedge clk) begin
    for (int g = 0; g < asu_pkg::NUM_GROUPS; g++) begin
      group_count[g] <= asu_pkg::GROUP_W'($countones(
        eq_pad[g*asu_pkg::GROUP_SIZE +: asu_pkg::GROUP_SIZE]));
    end
  end

  // sum of the registered group counts, valid in the cycle after eq settles
  always_comb begin
    count = '0;
    for (int g = 0; g < asu_pkg::NUM_GROUPS; g++) begin
      count = count + asu_pkg::CNT_W'(group_count[g]);
    end
  end

endmodule

// ===== tb/asu_result_checker.sv =====
// result checker for the array sort and statistics unit: channel watch, sort prediction, compare
module asu_result_checker
  import asu_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic signed [DATA_W-1:0]  match_value,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [DATA_W-1:0]  element,
  input  logic                      final_element,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [DATA_W-1:0]  sorted_value,
  input  logic                      end_of_run,
  input  logic signed [DATA_W-1:0]  largest,
  input  logic signed [DATA_W-1:0]  smallest,
  input  logic signed [SUM_W-1:0]   total,
  input  logic [MATCH_W-1:0]        match_count,
  input  logic                      overflowed,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic signed [DATA_W-1:0] hi;
    logic signed [DATA_W-1:0] lo;
    logic signed [SUM_W-1:0]  sum;
    logic [MATCH_W-1:0]       hits;
    logic                     dropped;
  } sorted_result_t;

  logic signed [DATA_W-1:0] held [CAPACITY];
  int                       held_n;
  logic                     dropped;
  logic signed [DATA_W-1:0] match_copy;
  sorted_result_t           sorted_due [$];

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    sorted_result_t want;
    if (sorted_due.size() == 0) begin
      $error("sorted_value: expected none, got %0d", sorted_value);
      errors++;
    end else begin
      want = sorted_due.pop_front();
      check_field("sorted_value", want.value, sorted_value);
      check_field("end_of_run", want.last, end_of_run);
      check_field("largest", want.hi, largest);
      check_field("smallest", want.lo, smallest);
      check_field("total", want.sum, total);
      check_field("match_count", want.hits, match_count);
      check_field("overflowed", want.dropped, overflowed);
    end
  endtask

  // store the value (or drop it when full); a closing item sorts and emits the set
  task automatic take_element(input logic signed [DATA_W-1:0] v, input logic last);
    sorted_result_t           r;
    logic signed [DATA_W-1:0] t;
    logic signed [SUM_W-1:0]  sum;
    logic [MATCH_W-1:0]       hits;
    int                       i;
    int                       j;
    if (held_n < CAPACITY) begin
      held[held_n] = v;
      held_n++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      for (i = 1; i < held_n; i++) begin
        t = held[i];
        j = i;
        while (j > 0 && held[j-1] > t) begin
          held[j] = held[j-1];
          j--;
        end
        held[j] = t;
      end
      sum  = '0;
      hits = '0;
      for (i = 0; i < held_n; i++) begin
        sum += held[i];
        if (held[i] == match_copy) hits++;
      end
      for (i = 0; i < held_n; i++) begin
        r.value   = held[i];
        r.last    = (i == held_n - 1);
        r.hi      = held[held_n-1];
        r.lo      = held[0];
        r.sum     = sum;
        r.hits    = hits;
        r.dropped = dropped;
        sorted_due.push_back(r);
      end
      held_n  = 0;
      dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_n     = 0;
      dropped    = 1'b0;
      match_copy = '0;
      errors     = 0;
      sorted_due.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) match_copy = match_value;
      if (in_valid && in_ready) take_element(element, final_element);
      pending <= sorted_due.size();
    end
  end

endmodule

// ===== tb/array_sort_and_statistics_unit_tb.sv =====
// top of the array sort and statistics unit testbench: stimulus, flow control and verdict
module array_sort_and_statistics_unit_tb;
  import asu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // random part size, settle time after the last result, run limit in cycles
  localparam int ITEMS  = 370;
  localparam int SETTLE = 8;
  localparam int LIMIT  = 400000;

  localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic signed [DATA_W-1:0]  match_value = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [DATA_W-1:0]  element = '0;
  logic                      final_element = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [DATA_W-1:0]  sorted_value;
  logic                      end_of_run;
  logic signed [DATA_W-1:0]  largest;
  logic signed [DATA_W-1:0]  smallest;
  logic signed [SUM_W-1:0]   total;
  logic [MATCH_W-1:0]        match_count;
  logic                      overflowed;
  int                        errors;
  int                        pending;

  // no idling on either side once this is set (tail of the run)
  logic                      calm = 1'b0;
  // match value currently loaded, so element picks can hit it
  logic signed [DATA_W-1:0]  match_setting = '0;

  array_sort_and_statistics_unit u_dut (.*);

  asu_result_checker u_checker (.*);

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  // run limit: worst case every item waits out the longest gaps and stalls
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // result side: ready and stall stretches of random length, no stalls once calm
  initial begin : drain
    int n;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 5);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 12);
      end
      repeat (n) @(posedge clk);
    end
  end

  // one input item; valid stays high into the next item unless a gap is taken
  task automatic push_element(input logic signed [DATA_W-1:0] v, input logic last);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    element       <= v;
    final_element <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // register write only with the block idle: set closed, every result out, pipeline drained
  task automatic write_match(input logic signed [DATA_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid   <= 1'b1;
    match_value <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    match_setting = v;
  endtask

  // element mix: match hits, extremes, small values around zero, negatives, full range
  function automatic logic signed [DATA_W-1:0] pick_element();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = match_setting;
      1: v = MOST_NEG;
      2: v = MOST_POS;
      3: begin
        v = $urandom_range(0, 20);
        v = v - 10;
      end
      4: v = $urandom | 32'h8000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_match();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = MOST_NEG;
      1: v = MOST_POS;
      2: v = '0;
      3: v = -1;
      4: begin
        v = $urandom_range(0, 20);
        v = v - 10;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int                       sent;
    int                       set_no;
    int                       len;
    int                       k;
    logic                     same;
    logic signed [DATA_W-1:0] base;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single value set with a match
    write_match(32'sd7);
    push_element(32'sd7, 1'b1);
    // extremes, zero, +-1 and two matches in one set
    push_element(MOST_NEG, 1'b0);
    push_element(MOST_POS, 1'b0);
    push_element(32'sd0, 1'b0);
    push_element(-32'sd1, 1'b0);
    push_element(32'sd1, 1'b0);
    push_element(32'sd7, 1'b0);
    push_element(32'sd7, 1'b1);
    // all negative set, maximum must be the true one, not zero
    push_element(-32'sd5, 1'b0);
    push_element(-32'sd100, 1'b0);
    push_element(-32'sd3, 1'b0);
    push_element(MOST_NEG, 1'b1);
    // equal values
    push_element(32'sd42, 1'b0);
    push_element(32'sd42, 1'b0);
    push_element(32'sd42, 1'b1);
    // alternating bit patterns
    push_element(32'sh5555_5555, 1'b0);
    push_element(32'shAAAA_AAAA, 1'b1);
    // match value at the extremes
    write_match(MOST_NEG);
    push_element(MOST_NEG, 1'b0);
    push_element(MOST_POS, 1'b0);
    push_element(MOST_NEG, 1'b1);
    write_match(MOST_POS);
    push_element(MOST_POS, 1'b1);

    // random sets: mostly short, now and then near or past capacity so the store
    // fills exactly or drops values (closing value included)
    sent   = 0;
    set_no = 0;
    while (sent < ITEMS) begin
      if (set_no % 6 == 5) write_match(pick_match());
      if (set_no == 2) len = CAPACITY + 2;
      else if (set_no == 5) len = CAPACITY;
      else if (set_no % 10 == 7) len = $urandom_range(CAPACITY - 2, CAPACITY + 4);
      else len = $urandom_range(1, 10);
      // some sets repeat one value, which can push match_count up to the capacity of 64
      same = ($urandom_range(0, 7) == 0);
      base = pick_element();
      for (k = 0; k < len; k++) begin
        push_element(same ? base : pick_element(), k == len - 1);
        sent++;
        if (sent >= ITEMS - 60) calm = 1'b1;
      end
      set_no++;
    end

    // drain, then let the pipeline settle before the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE * 4) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/asu_pkg.sv
design/asu_cell.sv
design/asu_match_counter.sv
design/array_sort_and_statistics_unit.sv
tb/asu_result_checker.sv
tb/array_sort_and_statistics_unit_tb.sv
